[design/spjq_pkg.sv]
// spjq_pkg: shared types and constants of the strict priority job queues.
// No dependencies.
`timescale 1ns / 1ps
package spjq_pkg;

  localparam int unsigned NumQueues  = 9;
  localparam int unsigned QueueDepth = 16;
  localparam int unsigned QW         = 4;
  localparam logic [QW-1:0] QNone    = 4'd15;

  typedef enum logic [2:0] {
    OpEnqueue  = 3'd0,
    OpReprio   = 3'd1,
    OpCancel   = 3'd2,
    OpPull     = 3'd3,
    OpFinished = 3'd4
  } opcode_e;

  typedef enum logic [1:0] {
    ErrNone    = 2'd0,
    ErrFull    = 2'd1,
    ErrInvalid = 2'd2
  } err_e;

  typedef struct packed {
    logic [2:0]    op;
    logic [15:0]   id;
    logic [2:0]    kind;
    logic          is_async;
    logic [QW-1:0] q_req;
    logic [QW-1:0] q_other;
    logic [QW-1:0] q_hi;
    logic [QW-1:0] q_lo;
  } cmd_t;

  function automatic logic [QW-1:0] route(logic [2:0] kind, logic is_async, logic high);
    logic [QW-1:0] q;
    q = QNone;
    if (is_async) begin
      if (kind == 3'd0) q = high ? 4'd7 : 4'd8;
    end else begin
      unique case (kind)
        3'd0:    q = high ? 4'd0 : 4'd2;
        3'd1:    q = high ? 4'd1 : 4'd5;
        3'd2:    q = 4'd3;
        3'd3:    q = 4'd4;
        3'd4:    q = 4'd6;
        default: q = QNone;
      endcase
    end
    return q;
  endfunction

endpackage

[design/spjq_front.sv]
// spjq_front: accepts request words, routes them and buffers them in a short queue.
// Depends on spjq_pkg.
`timescale 1ns / 1ps
module spjq_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [2:0]       opcode_i,
  input  logic [15:0]      job_id_i,
  input  logic [2:0]       job_kind_i,
  input  logic             is_async_i,
  input  logic             high_priority_i,
  output logic             cmd_valid_o,
  input  logic             cmd_pop_i,
  output spjq_pkg::cmd_t   cmd_o
);

  spjq_pkg::cmd_t buf_q [2];
  logic           wp_q, rp_q;
  logic [1:0]     cnt_q;
  spjq_pkg::cmd_t c;
  logic           push;

  always_comb begin
    c.op       = opcode_i;
    c.id       = job_id_i;
    c.kind     = job_kind_i;
    c.is_async = is_async_i;
    c.q_req    = spjq_pkg::route(job_kind_i, is_async_i, high_priority_i);
    c.q_other  = spjq_pkg::route(job_kind_i, is_async_i, ~high_priority_i);
    c.q_hi     = spjq_pkg::route(job_kind_i, is_async_i, 1'b1);
    c.q_lo     = spjq_pkg::route(job_kind_i, is_async_i, 1'b0);
  end

  assign in_stall_o  = (cnt_q == 2'd2);
  assign push        = in_valid_i && !in_stall_o;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = buf_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push) buf_q[wp_q] <= c;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (cmd_pop_i) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, cmd_pop_i};
    end
  end

endmodule

[design/spjq_back.sv]
// spjq_back: queue storage and the sequencer that carries out each request.
// Depends on spjq_pkg.
`timescale 1ns / 1ps
module spjq_back #(
  parameter int unsigned QUEUE_DEPTH = spjq_pkg::QueueDepth
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cmd_valid_i,
  output logic           cmd_pop_o,
  input  spjq_pkg::cmd_t cmd_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output logic           found_o,
  output logic           dispatch_valid_o,
  output logic [15:0]    dispatch_id_o,
  output logic           dispatch_async_o,
  output logic [1:0]     error_code_o
);

  localparam int unsigned PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned NQ = spjq_pkg::NumQueues;
  localparam int unsigned AW = $clog2(NQ * QUEUE_DEPTH);
  localparam int unsigned QW = spjq_pkg::QW;

  typedef enum logic [8:0] {
    SIdle   = 9'b000000001,
    SDecode = 9'b000000010,
    SRdReq  = 9'b000000100,
    SRdWait = 9'b000001000,
    SScan   = 9'b000010000,
    SShift  = 9'b000100000,
    SPop    = 9'b001000000,
    SPopDat = 9'b010000000,
    SOut    = 9'b100000000
  } state_e;

  state_e         st_q, st_d;
  spjq_pkg::cmd_t cmd_q;
  logic [PW-1:0]  head_q [NQ];
  logic [CW-1:0]  cnt_q  [NQ];
  logic           busy_q;
  logic [15:0]    mem [NQ*QUEUE_DEPTH];
  logic [15:0]    rd_q;

  logic [QW-1:0]  sq_q;
  logic [CW-1:0]  idx_q;
  logic           second_q;
  logic           async_pop_q;
  logic           found_q, dv_q, das_q;
  logic [15:0]    did_q;
  logic [1:0]     err_q;
  logic           ovalid_q;
  logic           ofound_q, odv_q, odas_q;
  logic [15:0]    odid_q;
  logic [1:0]     oerr_q;

  logic           we;
  logic [AW-1:0]  waddr, raddr;
  logic [15:0]    wdata;
  logic           re;

  function automatic logic [AW-1:0] addr(logic [QW-1:0] q, logic [PW-1:0] h,
                                         logic [CW-1:0] i);
    logic [CW:0] s;
    logic [PW-1:0] p;
    s = {1'b0, i} + {{(CW+1-PW){1'b0}}, h};
    if (s >= (CW+1)'(QUEUE_DEPTH)) s = s - (CW+1)'(QUEUE_DEPTH);
    p = s[PW-1:0];
    return AW'(q) * AW'(QUEUE_DEPTH) + AW'(p);
  endfunction

  assign out_valid_o      = ovalid_q;
  assign found_o          = ofound_q;
  assign dispatch_valid_o = odv_q;
  assign dispatch_id_o    = odid_q;
  assign dispatch_async_o = odas_q;
  assign error_code_o     = oerr_q;
  assign cmd_pop_o        = (st_q == SIdle) && cmd_valid_i;

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    if (re) rd_q <= mem[raddr];
  end

  // pull pick: first nonempty of queues 0..6
  logic [QW-1:0] pull_q;
  logic          pull_any;
  always_comb begin
    pull_q   = spjq_pkg::QNone;
    pull_any = 1'b0;
    for (int k = 6; k >= 0; k--) begin
      if (cnt_q[k] != '0) begin
        pull_q   = QW'(k);
        pull_any = 1'b1;
      end
    end
  end

  logic [QW-1:0] aq;
  logic          a_any;
  always_comb begin
    a_any = (cnt_q[7] != '0) || (cnt_q[8] != '0);
    aq    = (cnt_q[7] != '0) ? QW'(7) : QW'(8);
  end

  logic full_req;
  assign full_req = (cmd_q.q_req != spjq_pkg::QNone) &&
                    (cnt_q[cmd_q.q_req] == CW'(QUEUE_DEPTH));

  always_comb begin
    st_d  = st_q;
    we    = 1'b0;
    waddr = '0;
    wdata = '0;
    re    = 1'b0;
    raddr = '0;
    unique case (st_q)
      SIdle:   if (cmd_valid_i) st_d = SDecode;
      SDecode: begin
        st_d = SOut;
        priority case (cmd_q.op)
          spjq_pkg::OpEnqueue: begin
            if (cmd_q.q_req != spjq_pkg::QNone && !full_req) begin
              we    = 1'b1;
              waddr = addr(cmd_q.q_req, head_q[cmd_q.q_req], cnt_q[cmd_q.q_req]);
              wdata = cmd_q.id;
              if (cmd_q.is_async && !busy_q) st_d = SPop;
            end
          end
          spjq_pkg::OpReprio: begin
            if (cmd_q.q_req != spjq_pkg::QNone && cmd_q.kind <= 3'd1) st_d = SRdReq;
          end
          spjq_pkg::OpCancel: begin
            if (cmd_q.q_req != spjq_pkg::QNone) st_d = SRdReq;
          end
          spjq_pkg::OpPull:     if (pull_any) st_d = SPop;
          spjq_pkg::OpFinished: st_d = SPop;
          default: st_d = SOut;
        endcase
      end
      SRdReq: begin
        if (idx_q >= cnt_q[sq_q]) begin
          if (cmd_q.op == spjq_pkg::OpCancel && !second_q &&
              cmd_q.q_lo != cmd_q.q_hi) st_d = SRdReq;
          else st_d = SOut;
        end else begin
          re    = 1'b1;
          raddr = addr(sq_q, head_q[sq_q], idx_q);
          st_d  = SRdWait;
        end
      end
      SRdWait: st_d = SScan;
      SScan: begin
        if (rd_q == cmd_q.id) begin
          if (cmd_q.op == spjq_pkg::OpReprio && full_req) st_d = SOut;
          else st_d = SShift;
        end else st_d = SRdReq;
      end
      SShift: begin
        if (idx_q + CW'(1) < cnt_q[sq_q]) begin
          re    = 1'b1;
          raddr = addr(sq_q, head_q[sq_q], idx_q + CW'(1));
          st_d  = SPopDat;
        end else begin
          if (cmd_q.op == spjq_pkg::OpReprio) begin
            we    = 1'b1;
            waddr = addr(cmd_q.q_req, head_q[cmd_q.q_req], cnt_q[cmd_q.q_req]);
            wdata = cmd_q.id;
          end
          st_d = SOut;
        end
      end
      SPop: begin
        if (cmd_q.op == spjq_pkg::OpPull || a_any) begin
          re    = 1'b1;
          raddr = addr(sq_q, head_q[sq_q], '0);
          st_d  = SPopDat;
        end else st_d = SOut;
      end
      SPopDat: begin
        if (async_pop_q) st_d = SOut;
        else begin
          // shift step of a delete: write moved entry back one slot
          we    = 1'b1;
          waddr = addr(sq_q, head_q[sq_q], idx_q);
          wdata = rd_q;
          st_d  = SShift;
        end
      end
      SOut:    if (!ovalid_q || !out_stall_i) st_d = SIdle;
      default: st_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= SIdle;
      busy_q   <= 1'b0;
      ovalid_q <= 1'b0;
      for (int k = 0; k < NQ; k++) begin
        head_q[k] <= '0;
        cnt_q[k]  <= '0;
      end
      sq_q        <= '0;
      idx_q       <= '0;
      second_q    <= 1'b0;
      async_pop_q <= 1'b0;
      found_q     <= 1'b0;
      dv_q        <= 1'b0;
      das_q       <= 1'b0;
      did_q       <= '0;
      err_q       <= '0;
      ofound_q    <= 1'b0;
      odv_q       <= 1'b0;
      odas_q      <= 1'b0;
      odid_q      <= '0;
      oerr_q      <= '0;
    end else begin
      st_q <= st_d;
      if (ovalid_q && !out_stall_i) ovalid_q <= 1'b0;
      unique case (st_q)
        SIdle: begin
          if (cmd_valid_i) cmd_q <= cmd_i;
          found_q <= 1'b0; dv_q <= 1'b0; das_q <= 1'b0;
          did_q <= '0; err_q <= spjq_pkg::ErrNone;
          idx_q <= '0; second_q <= 1'b0; async_pop_q <= 1'b0;
        end
        SDecode: begin
          priority case (cmd_q.op)
            spjq_pkg::OpEnqueue: begin
              if (cmd_q.q_req == spjq_pkg::QNone) err_q <= spjq_pkg::ErrInvalid;
              else if (full_req) err_q <= spjq_pkg::ErrFull;
              else cnt_q[cmd_q.q_req] <= cnt_q[cmd_q.q_req] + CW'(1);
              sq_q <= aq;
              async_pop_q <= 1'b1;
              // the pop source is queue 7 whenever the new job itself goes to queue 7
              if (cmd_q.q_req == QW'(7)) sq_q <= QW'(7);
            end
            spjq_pkg::OpReprio: begin
              if (cmd_q.q_req == spjq_pkg::QNone || cmd_q.kind > 3'd1)
                err_q <= spjq_pkg::ErrInvalid;
              sq_q <= cmd_q.q_other;
            end
            spjq_pkg::OpCancel: begin
              if (cmd_q.q_req == spjq_pkg::QNone) err_q <= spjq_pkg::ErrInvalid;
              sq_q <= cmd_q.q_hi;
            end
            spjq_pkg::OpPull: begin
              sq_q <= pull_q;
            end
            spjq_pkg::OpFinished: begin
              busy_q <= 1'b0;
              sq_q <= aq;
              async_pop_q <= 1'b1;
            end
            default: ;
          endcase
        end
        SRdReq: begin
          if (idx_q >= cnt_q[sq_q]) begin
            second_q <= 1'b1;
            idx_q    <= '0;
            sq_q     <= cmd_q.q_lo;
          end
        end
        SRdWait: ;
        SScan: begin
          if (rd_q == cmd_q.id) begin
            if (cmd_q.op == spjq_pkg::OpReprio && full_req) err_q <= spjq_pkg::ErrFull;
            else found_q <= 1'b1;
          end else idx_q <= idx_q + CW'(1);
        end
        SShift: begin
          if (!(idx_q + CW'(1) < cnt_q[sq_q])) begin
            cnt_q[sq_q] <= cnt_q[sq_q] - CW'(1);
            if (cmd_q.op == spjq_pkg::OpReprio)
              cnt_q[cmd_q.q_req] <= cnt_q[cmd_q.q_req] + CW'(1);
          end
        end
        SPop: begin
          if (cmd_q.op == spjq_pkg::OpPull || a_any) begin
            async_pop_q <= 1'b1;
            if (cmd_q.op != spjq_pkg::OpPull) busy_q <= 1'b1;
          end
        end
        SPopDat: begin
          if (async_pop_q) begin
            dv_q  <= 1'b1;
            did_q <= rd_q;
            das_q <= (cmd_q.op != spjq_pkg::OpPull);
            cnt_q[sq_q]  <= cnt_q[sq_q] - CW'(1);
            head_q[sq_q] <= (head_q[sq_q] == PW'(QUEUE_DEPTH - 1)) ? '0 :
                            head_q[sq_q] + PW'(1);
          end else idx_q <= idx_q + CW'(1);
        end
        SOut: begin
          if (!ovalid_q || !out_stall_i) begin
            ovalid_q <= 1'b1;
            ofound_q <= found_q;
            odv_q    <= dv_q;
            odid_q   <= did_q;
            odas_q   <= das_q;
            oerr_q   <= err_q;
          end
        end
        default: ;
      endcase
      // async enqueue: pick queue after this job's count is in
      if (st_q == SDecode && cmd_q.op == spjq_pkg::OpEnqueue) begin
        if (cmd_q.q_req == QW'(7) || cnt_q[7] != '0) sq_q <= QW'(7);
        else sq_q <= QW'(8);
      end
    end
  end

endmodule

[design/strict_priority_job_queues.sv]
// Enqueue, pull and finished go through decode and output, with a head read added when
// a job is dispatched; cancel and reprioritize scan each queue searched entry by entry
// and shift the later entries back one slot. One request is carried out at a time by
// the back sequencer; a two-word front queue accepts requests meanwhile.
// Async reset clears all heads, counts and the async busy flag; entry storage
// holds no reset.
`timescale 1ns / 1ps
module strict_priority_job_queues #(
  parameter int unsigned QUEUE_DEPTH = spjq_pkg::QueueDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  opcode_i,
  input  logic [15:0] job_id_i,
  input  logic [2:0]  job_kind_i,
  input  logic        is_async_i,
  input  logic        high_priority_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        found_o,
  output logic        dispatch_valid_o,
  output logic [15:0] dispatch_id_o,
  output logic        dispatch_async_o,
  output logic [1:0]  error_code_o
);

  logic           cmd_valid, cmd_pop;
  spjq_pkg::cmd_t cmd;

  spjq_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o,
    .opcode_i, .job_id_i, .job_kind_i, .is_async_i, .high_priority_i,
    .cmd_valid_o(cmd_valid), .cmd_pop_i(cmd_pop), .cmd_o(cmd)
  );

  spjq_back #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_back (
    .clk_i, .rst_ni,
    .cmd_valid_i(cmd_valid), .cmd_pop_o(cmd_pop), .cmd_i(cmd),
    .out_valid_o, .out_stall_i, .found_o, .dispatch_valid_o,
    .dispatch_id_o, .dispatch_async_o, .error_code_o
  );

endmodule
